// ===== src/gbs_pkg.sv =====
package gbs_pkg;

	// Number of kept boxes the ring of cells can hold.
	localparam int MAX_KEPT = 64;
	// Pipeline depth of the shared overlap unit.
	localparam int IOU_LAT = 4;
	localparam int TOTAL_W = $clog2(MAX_KEPT + 1);
	localparam int CNT_W = $clog2(MAX_KEPT + IOU_LAT);
	localparam int SLOT_W = 6;
	localparam int THR_W = 9;
	localparam logic [THR_W-1:0] THR_RESET = 9'd115;

	typedef struct packed {
		logic signed [17:0] left;
		logic signed [17:0] top;
		logic signed [17:0] right;
		logic signed [17:0] bottom;
		logic [31:0] area;
	} kept_box_t;

	typedef struct packed {
		logic valid;
		logic suppress;
	} iou_res_t;

endpackage

// ===== src/gbs_in_if.sv =====
interface gbs_in_if;
	logic valid;
	logic ready;
	logic first_of_frame;
	logic signed [16:0] box_left;
	logic signed [16:0] box_top;
	logic [15:0] box_width;
	logic [15:0] box_height;

	modport source(output valid, first_of_frame, box_left, box_top, box_width, box_height,
		input ready);
	modport sink(input valid, first_of_frame, box_left, box_top, box_width, box_height,
		output ready);
endinterface

// ===== src/gbs_out_if.sv =====
interface gbs_out_if;
	logic valid;
	logic ready;
	logic keep;
	logic [15:0] proposal_index;
	logic [5:0] kept_slot;
	logic store_full;

	modport source(output valid, keep, proposal_index, kept_slot, store_full, input ready);
	modport sink(input valid, keep, proposal_index, kept_slot, store_full, output ready);
endinterface

// ===== src/gbs_cell.sv =====
module gbs_cell (
	input logic clk,
	input logic shift,
	input logic load,
	input gbs_pkg::kept_box_t nbr,
	input gbs_pkg::kept_box_t wr_box,
	output gbs_pkg::kept_box_t box
);
	import gbs_pkg::*;

	kept_box_t box_q;

	always_ff @(posedge clk) begin
		if (load) begin
			box_q <= wr_box;
		end else if (shift) begin
			box_q <= nbr;
		end
	end

	assign box = box_q;

endmodule

// ===== src/gbs_iou.sv =====
module gbs_iou (
	input logic clk,
	input logic arst_n,
	input logic en,
	input gbs_pkg::kept_box_t query,
	input gbs_pkg::kept_box_t kept,
	input logic [8:0] thr,
	output gbs_pkg::iou_res_t res
);
	import gbs_pkg::*;

	logic signed [17:0] q_l, q_t, q_r, q_b, k_l, k_t, k_r, k_b;
	logic signed [17:0] min_r, max_l, min_b, max_t;
	logic [18:0] iw, ih;
	logic ovl;

	logic vld_s1, vld_s2, vld_s3;
	logic ok_s1, ok_s2, ok_s3;
	logic [15:0] iw_s1, ih_s1;
	logic [32:0] sum_s1, sum_s2;
	logic [31:0] inter_s2, inter_s3;
	logic [32:0] uni;
	logic [41:0] prod;
	logic [41:0] prod_s3;
	iou_res_t res_q;

	assign q_l = query.left;
	assign q_t = query.top;
	assign q_r = query.right;
	assign q_b = query.bottom;
	assign k_l = kept.left;
	assign k_t = kept.top;
	assign k_r = kept.right;
	assign k_b = kept.bottom;

	always_comb begin
		min_r = (q_r < k_r) ? q_r : k_r;
		max_l = (q_l > k_l) ? q_l : k_l;
		min_b = (q_b < k_b) ? q_b : k_b;
		max_t = (q_t > k_t) ? q_t : k_t;
		iw = {min_r[17], min_r} - {max_l[17], max_l};
		ih = {min_b[17], min_b} - {max_t[17], max_t};
		// A positive overlap can never exceed the query width, so 16 bits carry it.
		ovl = !iw[18] && (iw != '0) && !ih[18] && (ih != '0);
	end

	assign uni = sum_s2 - {1'b0, inter_s2};
	assign prod = {33'd0, thr} * {9'd0, uni};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			res_q <= '0;
		end else begin
			vld_s1 <= en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			res_q.valid <= vld_s3;
			res_q.suppress <= vld_s3 && ok_s3 && ({2'b00, inter_s3, 8'h00} > prod_s3);
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= en && ovl;
		iw_s1 <= iw[15:0];
		ih_s1 <= ih[15:0];
		sum_s1 <= {1'b0, query.area} + {1'b0, kept.area};
		ok_s2 <= ok_s1;
		inter_s2 <= iw_s1 * ih_s1;
		sum_s2 <= sum_s1;
		ok_s3 <= ok_s2;
		inter_s3 <= inter_s2;
		prod_s3 <= prod;
	end

	assign res = res_q;

endmodule

// ===== src/greedy_box_suppression.sv =====
// Each accepted box is compared with the kept boxes as they rotate once around the
// ring of cells, one per cycle, through a single four-stage overlap unit; the next box
// is not taken before the result of this one is registered.
// A new box is accepted while the previous result still waits to be taken.
// Reset (arst_n low) empties the kept list, clears the position count and sets the
// overlap threshold to 115; stored box contents are not cleared.
module greedy_box_suppression (
	input logic clk,
	input logic arst_n,
	gbs_in_if.sink boxes,
	gbs_out_if.source results,
	input logic cfg_we,
	input logic [8:0] cfg_wdata
);
	import gbs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TOTAL_W-1:0] kept_total_q;
	logic [15:0] pc_q;
	logic [15:0] pos_q;
	logic [8:0] thr_q;
	logic sup_q;
	kept_box_t query_q;

	logic out_valid_q, keep_q, full_q;
	logic [15:0] index_q;
	logic [SLOT_W-1:0] slot_q;

	logic accept, feed, cmp_en, finish, store;
	logic [15:0] pc_base;
	logic signed [17:0] new_r, new_b;
	kept_box_t ring [MAX_KEPT];
	iou_res_t iou_res;

	assign boxes.ready = (state_q == ST_IDLE);
	assign accept = boxes.valid && (state_q == ST_IDLE);
	assign feed = (state_q == ST_RUN) && (cnt_q < CNT_W'(MAX_KEPT));
	assign cmp_en = feed && (cnt_q < CNT_W'(kept_total_q));
	assign finish = (state_q == ST_DONE) && (!out_valid_q || results.ready);
	assign store = finish && !sup_q && (kept_total_q < TOTAL_W'(MAX_KEPT));

	assign pc_base = boxes.first_of_frame ? 16'd0 : pc_q;
	assign new_r = $signed({boxes.box_left[16], boxes.box_left}) +
		$signed({2'b00, boxes.box_width});
	assign new_b = $signed({boxes.box_top[16], boxes.box_top}) +
		$signed({2'b00, boxes.box_height});

	// Cell i takes its neighbor's box on every step, so the head sees entry k at step k
	// and after MAX_KEPT steps the ring is back in place.
	for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
		gbs_cell u_cell (
			.clk(clk),
			.shift(feed),
			.load(store && (kept_total_q == TOTAL_W'(i))),
			.nbr(ring[(i + 1) % MAX_KEPT]),
			.wr_box(query_q),
			.box(ring[i])
		);
	end

	gbs_iou u_iou (
		.clk(clk),
		.arst_n(arst_n),
		.en(cmp_en),
		.query(query_q),
		.kept(ring[0]),
		.thr(thr_q),
		.res(iou_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			kept_total_q <= '0;
			pc_q <= '0;
			pos_q <= '0;
			thr_q <= THR_RESET;
			sup_q <= 1'b0;
			out_valid_q <= 1'b0;
			keep_q <= 1'b0;
			full_q <= 1'b0;
			index_q <= '0;
			slot_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			priority if (finish) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (boxes.first_of_frame) begin
							kept_total_q <= '0;
						end
						// The output register may still hold an untaken beat.
						pos_q <= pc_base;
						pc_q <= (pc_base == 16'hFFFF) ? pc_base : pc_base + 16'd1;
						cnt_q <= '0;
						sup_q <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (iou_res.valid && iou_res.suppress) begin
						sup_q <= 1'b1;
					end
					if (cnt_q == CNT_W'(MAX_KEPT + IOU_LAT - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (finish) begin
						index_q <= pos_q;
						keep_q <= !sup_q;
						full_q <= !sup_q && !store;
						slot_q <= store ? SLOT_W'(kept_total_q) : '0;
						if (store) begin
							kept_total_q <= kept_total_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q.left <= {boxes.box_left[16], boxes.box_left};
			query_q.top <= {boxes.box_top[16], boxes.box_top};
			query_q.right <= new_r;
			query_q.bottom <= new_b;
			query_q.area <= boxes.box_width * boxes.box_height;
		end
	end

	assign results.valid = out_valid_q;
	assign results.keep = keep_q;
	assign results.proposal_index = index_q;
	assign results.kept_slot = slot_q;
	assign results.store_full = full_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_total_q <= TOTAL_W'(MAX_KEPT))
		else $error("kept box count exceeds store size");

	a_res_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		iou_res.valid |-> (state_q == ST_RUN))
		else $error("overlap result outside of a ring pass");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(boxes.valid && boxes.ready) |=> (state_q == ST_RUN && cnt_q == '0))
		else $error("accepted beat did not start a ring pass");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.keep) |-> (!results.store_full && results.kept_slot == '0))
		else $error("suppressed box carries store fields");

endmodule

// ===== tb/greedy_box_suppression_tb.sv =====
`timescale 1ns / 100ps

module greedy_box_suppression_tb;

	import gbs_pkg::*;

	localparam int ITEM_TARGET = 1750;
	localparam int HOLD_CYCLES = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_DIRECTED = 22;

	typedef struct packed {
		logic keep;
		logic [15:0] pos;
		logic [5:0] slot;
		logic full;
	} box_verdict_t;

	typedef struct packed {
		logic wr;
		logic [8:0] thr;
		logic first;
		logic signed [16:0] left;
		logic signed [16:0] top;
		logic [15:0] wd;
		logic [15:0] ht;
		logic typed;
		box_verdict_t want;
	} directed_row_t;

	// Rows with typed = 1 carry the verdict that follows directly from the geometry.
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		'{0,   0, 0,      0,      0,    16,    16, 1, '{1, 0, 0, 0}},
		'{0,   0, 0,      0,      0,    16,    16, 1, '{0, 1, 0, 0}},
		'{0,   0, 1, -65536, -65536, 65535, 65535, 1, '{1, 0, 0, 0}},
		'{0,   0, 0,  65535,  65535, 65535, 65535, 1, '{1, 1, 1, 0}},
		'{0,   0, 0,     -1, -65536,    10,    10, 1, '{1, 2, 2, 0}},
		'{0,   0, 0,      0,      0,     0,     0, 0, '{0, 0, 0, 0}},
		'{0,   0, 0,      0,      0,     0,     0, 0, '{0, 0, 0, 0}},
		'{0,   0, 0,  -1000,  -1000,    16,    16, 0, '{0, 0, 0, 0}},
		'{0,   0, 0,  -1000,  -1000,    16,    16, 0, '{0, 0, 0, 0}},
		'{1,   0, 1,      0,      0,   100,   100, 1, '{1, 0, 0, 0}},
		'{0,   0, 0,     99,     99,   100,   100, 1, '{0, 1, 0, 0}},
		'{0,   0, 0,    100,      0,    50,    50, 1, '{1, 2, 1, 0}},
		'{1, 256, 1,      5,      5,    32,    32, 1, '{1, 0, 0, 0}},
		'{0,   0, 0,      5,      5,    32,    32, 1, '{1, 1, 1, 0}},
		'{1, 511, 0,      5,      5,    32,    32, 1, '{1, 2, 2, 0}},
		'{1, 255, 0,      5,      5,    32,    32, 1, '{0, 3, 0, 0}},
		'{0,   0, 0,      6,      5,    32,    32, 0, '{0, 0, 0, 0}},
		'{1, 115, 1,      0,      0,   100,   100, 1, '{1, 0, 0, 0}},
		'{0,   0, 0,     38,      0,   100,   100, 1, '{0, 1, 0, 0}},
		'{0,   0, 0,     39,      0,   100,   100, 1, '{1, 2, 1, 0}},
		'{0,   0, 0,      0,      0, 65535,     0, 0, '{0, 0, 0, 0}},
		'{0,   0, 1,  65535, -65536,     0, 65535, 0, '{0, 0, 0, 0}}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [8:0] cfg_wdata;

	gbs_in_if box_ch();
	gbs_out_if res_ch();

	greedy_box_suppression u_top (
		.clk(clk),
		.arst_n(arst_n),
		.boxes(box_ch),
		.results(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Shadow of the kept list, the frame position and the threshold.
	logic signed [17:0] mem_left [MAX_KEPT];
	logic signed [17:0] mem_top [MAX_KEPT];
	logic signed [17:0] mem_right [MAX_KEPT];
	logic signed [17:0] mem_bottom [MAX_KEPT];
	logic [31:0] mem_area [MAX_KEPT];
	int mem_fill = 0;
	logic [15:0] next_pos = '0;
	logic [8:0] iou_limit = THR_RESET;

	box_verdict_t verdicts_due [$];

	int src_max_gap = 13;
	int sink_max_stall = 13;
	bit hold_request = 0;
	int holds_done = 0;
	int boxes_sent = 0;
	int results_seen = 0;
	int kept_seen = 0;
	int full_seen = 0;
	int thr_writes = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	function automatic box_verdict_t judge_box(input logic first,
			input logic signed [16:0] left, input logic signed [16:0] top,
			input logic [15:0] wd, input logic [15:0] ht);
		longint l, t, r, b, area, iw, ih, inter, uni;
		box_verdict_t v;
		bit survive;
		if (first) begin
			mem_fill = 0;
			next_pos = '0;
		end
		l = left;
		t = top;
		r = l + longint'(wd);
		b = t + longint'(ht);
		area = longint'(wd) * longint'(ht);
		survive = 1;
		for (int i = 0; i < mem_fill; i++) begin
			iw = ((r < mem_right[i]) ? r : mem_right[i]) - ((l > mem_left[i]) ? l : mem_left[i]);
			ih = ((b < mem_bottom[i]) ? b : mem_bottom[i]) - ((t > mem_top[i]) ? t : mem_top[i]);
			if (iw > 0 && ih > 0) begin
				inter = iw * ih;
				uni = area + longint'(mem_area[i]) - inter;
				if (inter * 256 > longint'(iou_limit) * uni)
					survive = 0;
			end
		end
		v = '0;
		v.keep = survive;
		v.pos = next_pos;
		if (next_pos != 16'hFFFF)
			next_pos++;
		if (survive) begin
			if (mem_fill < MAX_KEPT) begin
				mem_left[mem_fill] = 18'(l);
				mem_top[mem_fill] = 18'(t);
				mem_right[mem_fill] = 18'(r);
				mem_bottom[mem_fill] = 18'(b);
				mem_area[mem_fill] = 32'(area);
				v.slot = 6'(mem_fill);
				mem_fill++;
			end else begin
				v.full = 1'b1;
			end
		end
		return v;
	endfunction

	function automatic logic signed [16:0] edge17(input int v);
		if (v < -65536)
			return 17'sh10000;
		if (v > 65535)
			return 17'sh0FFFF;
		return 17'(v);
	endfunction

	function automatic logic [15:0] span16(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return 16'hFFFF;
		return 16'(v);
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_box(input logic first, input logic signed [16:0] left,
			input logic signed [16:0] top, input logic [15:0] wd, input logic [15:0] ht,
			input logic typed, input box_verdict_t typed_v);
		int unsigned gap;
		box_verdict_t v;
		gap = $urandom_range(0, src_max_gap);
		@(negedge clk);
		if (gap != 0) begin
			box_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		box_ch.valid = 1'b1;
		box_ch.first_of_frame = first;
		box_ch.box_left = left;
		box_ch.box_top = top;
		box_ch.box_width = wd;
		box_ch.box_height = ht;
		do @(posedge clk); while (box_ch.ready !== 1'b1);
		v = judge_box(first, left, top, wd, ht);
		if (typed)
			v = typed_v;
		verdicts_due = {verdicts_due, v};
		boxes_sent++;
	endtask

	// The threshold only changes once every result in flight has come back.
	task automatic set_threshold(input logic [8:0] thr);
		@(negedge clk);
		box_ch.valid = 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = thr;
		@(negedge clk);
		cfg_we = 1'b0;
		iou_limit = thr;
		thr_writes++;
	endtask

	initial begin
		int unsigned frames, kind, n, nclus, c;
		int ox, oy, side, lx, ty, wd, ht, block;
		int cx [4];
		int cy [4];
		int cw [4];
		int ch [4];
		logic [8:0] thr;
		box_verdict_t no_typed;
		no_typed = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		box_ch.valid = 1'b0;
		box_ch.first_of_frame = 1'b0;
		box_ch.box_left = '0;
		box_ch.box_top = '0;
		box_ch.box_width = '0;
		box_ch.box_height = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < NUM_DIRECTED; r++) begin
			if (DIRECTED[r].wr)
				set_threshold(DIRECTED[r].thr);
			send_box(DIRECTED[r].first, DIRECTED[r].left, DIRECTED[r].top, DIRECTED[r].wd,
				DIRECTED[r].ht, DIRECTED[r].typed, DIRECTED[r].want);
		end

		block = 0;
		while (boxes_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 7))
				0: thr = 9'd0;
				1: thr = 9'd511;
				2: thr = 9'd256;
				3: thr = 9'd255;
				4: thr = THR_RESET;
				5: thr = 9'd1;
				default: thr = 9'($urandom_range(0, 511));
			endcase
			set_threshold(thr);
			if (block == 2) begin
				// Long result stall while boxes keep coming, so the input backs up.
				hold_request = 1;
				src_max_gap = 0;
				sink_max_stall = 13;
			end else if ($urandom_range(0, 3) == 0) begin
				src_max_gap = 0;
				sink_max_stall = 0;
			end else begin
				src_max_gap = 13;
				sink_max_stall = 13;
			end
			frames = $urandom_range(2, 5);
			repeat (frames) if (boxes_sent < ITEM_TARGET) begin
				kind = $urandom_range(0, 9);
				if (kind < 3) begin
					// A tiled frame that may overrun the store, with some boxes repeated.
					n = $urandom_range(60, 90);
					ox = int'($urandom_range(0, 100000)) - 50000;
					oy = int'($urandom_range(0, 100000)) - 50000;
					side = $urandom_range(32, 240);
					for (int i = 0; i < n; i++) begin
						c = (i > 0 && $urandom_range(0, 4) == 0) ? $urandom_range(0, i - 1) : i;
						lx = ox + int'(c % 10) * 256 + int'($urandom_range(0, 3));
						ty = oy + int'(c / 10) * 256;
						send_box(i == 0, edge17(lx), edge17(ty), span16(side), span16(side),
							0, no_typed);
					end
				end else if (kind < 9) begin
					// Overlapping clusters around a few centers; kind 8 omits the frame flag.
					nclus = $urandom_range(1, 4);
					for (int k = 0; k < nclus; k++) begin
						cx[k] = int'($urandom_range(0, 120000)) - 60000;
						cy[k] = int'($urandom_range(0, 120000)) - 60000;
						cw[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40000)
							: $urandom_range(16, 3000);
						ch[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40000)
							: $urandom_range(16, 3000);
					end
					n = $urandom_range(4, 30);
					for (int i = 0; i < n; i++) begin
						c = $urandom_range(0, nclus - 1);
						wd = cw[c] + jitter(cw[c] / 3);
						ht = ch[c] + jitter(ch[c] / 3);
						if ($urandom_range(0, 15) == 0)
							wd = 0;
						if ($urandom_range(0, 15) == 0)
							ht = 0;
						lx = cx[c] - wd / 2 + jitter(cw[c] / 4);
						ty = cy[c] - ht / 2 + jitter(ch[c] / 4);
						send_box(i == 0 && kind != 8, edge17(lx), edge17(ty), span16(wd),
							span16(ht), 0, no_typed);
					end
				end else begin
					n = $urandom_range(1, 10);
					repeat (n) send_box($urandom_range(0, 3) == 0, 17'($urandom),
						17'($urandom), 16'($urandom), 16'($urandom), 0, no_typed);
				end
			end
			block++;
		end

		@(negedge clk);
		box_ch.valid = 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (MAX_KEPT + 6 + 16) @(posedge clk);

		$display("Checked %0d of %0d boxes, %0d threshold writes, %0d kept, %0d past a full store.",
			results_seen, boxes_sent, thr_writes, kept_seen, full_seen);
		$display("Tiled fills, overlap clusters and random boxes; result port held off %0d time(s).",
			holds_done);
		if (mismatches == 0) begin
			$display("greedy_box_suppression verification clean");
		end else begin
			$display("greedy_box_suppression verification failed");
		end
		$finish;
	end

	initial begin
		int unsigned stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 0;
				holds_done++;
			end else begin
				stall = $urandom_range(0, sink_max_stall);
			end
			if (stall != 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		box_verdict_t want;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: extra result beat keep=%0b index=%0d slot=%0d full=%0b",
						$realtime, res_ch.keep, res_ch.proposal_index, res_ch.kept_slot,
						res_ch.store_full);
			end else begin
				want = verdicts_due.pop_front();
				if (res_ch.keep !== want.keep || res_ch.proposal_index !== want.pos
						|| res_ch.kept_slot !== want.slot || res_ch.store_full !== want.full) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result %0d expected keep=%0b index=%0d slot=%0d full=%0b",
							$realtime, results_seen, want.keep, want.pos, want.slot, want.full);
						$display("    got keep=%0b index=%0d slot=%0d full=%0b",
							res_ch.keep, res_ch.proposal_index, res_ch.kept_slot,
							res_ch.store_full);
					end
				end
				results_seen++;
				if (want.keep)
					kept_seen++;
				if (want.full)
					full_seen++;
			end
		end
	end

	// Ends a hung run: counts cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if ((box_ch.valid === 1'b1 && box_ch.ready === 1'b1)
				|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("greedy_box_suppression verification failed");
				$finish;
			end
		end
	end

endmodule
